### rtl/gcft_pkg.sv
// Shared types, constants and tables for the great-circle flight time unit.
package gcft_pkg;

  // CORDIC depth, legal range 12..32
  localparam int CORDIC_STAGES = 24;
  localparam int SQRT_STEPS    = 31;
  localparam int DIV_STEPS     = 29;
  localparam int PREP_LAT      = 4;
  localparam int PIPE_DEPTH    = 1 + PREP_LAT + CORDIC_STAGES + 3 + SQRT_STEPS
                                 + CORDIC_STAGES + 3 + DIV_STEPS + 1;

  localparam int ANG_W  = 30;  // angle in half-microdegrees
  localparam int MAG_W  = 28;  // folded angle magnitude
  localparam int Z_W    = 31;  // Q30 radians, first quadrant
  localparam int CW     = 34;  // CORDIC datapath
  localparam int RAD_W  = 17;
  localparam int SPD_W  = 10;
  localparam int DIST_W = 22;
  localparam int TIME_W = 29;

  localparam logic signed [ANG_W:0] TURN_HU    = 31'sd720000000;
  localparam logic signed [ANG_W:0] HALF_HU    = 31'sd360000000;
  localparam logic signed [ANG_W:0] QUARTER_HU = 31'sd180000000;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [71:0] P2_71       = 72'd1 << 71;
  // ceil(2^71 / 703125): exact reciprocal for the angle scale divide
  localparam logic [51:0] ANG_RECIP   = 52'((P2_71 / 72'd703125) + 72'd1);

  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
  localparam logic [30:0] Q30_ONE  = 31'd1073741824;
  localparam logic [DIST_W-1:0] DIST_MAX = 22'd4194303;
  localparam logic [TIME_W-1:0] TIME_MAX = 29'd536870911;
  localparam logic [RAD_W-1:0]  RADIUS_RESET = 17'd39588;
  localparam logic [SPD_W-1:0]  SPEED_RESET  = 10'd500;

  // config register indexes
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_SPEED  = 1'b1;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001, 30'h00000000
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flag;
  } cordic_t;

  typedef struct packed {
    logic [61:0] rad;
    logic [32:0] rem;
    logic [30:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [TIME_W-1:0] num;
    logic [SPD_W-1:0]  rem;
    logic [TIME_W-1:0] quo;
    logic [DIST_W-1:0] distance;
  } div_t;

endpackage

### rtl/great_circle_flight_time_unit.sv
// Top level: haversine great-circle distance and travel time pipeline.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, start/end lat/lon            | item in
//  out     | out_valid, out_stall, arc_distance, travel_time  | item out
//  cfg     | cfg_write, cfg_index, cfg_data                   | reg write
//
// One item per cycle while the sink does not stall the output; the pipeline is
// made up of the two CORDIC chains, the 31-step square root and 29-step divider.
// The whole pipeline advances together; it holds only while the output
// register has an item that the sink stalls.
// Synchronous active-high reset clears the valid line and loads the config registers with their reset values.
module great_circle_flight_time_unit import gcft_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [27:0]      start_latitude,
  input  logic signed [28:0]      start_longitude,
  input  logic signed [27:0]      end_latitude,
  input  logic signed [28:0]      end_longitude,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DIST_W-1:0]       arc_distance,
  output logic [TIME_W-1:0]       travel_time,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [RAD_W-1:0]        cfg_data
);

  logic [RAD_W-1:0] sphere_radius;
  logic [SPD_W-1:0] travel_speed;

  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld;

  // angle lanes: 0 dlat, 1 dlon, 2 lat1 (doubled), 3 lat2 (doubled)
  logic signed [ANG_W-1:0] ang [4];
  logic [Z_W-1:0]          prep_z [4];
  logic                    prep_flip [4];
  cordic_t                 rot [4][CORDIC_STAGES+1];

  sqrt_t   sq_y [SQRT_STEPS+1];
  sqrt_t   sq_x [SQRT_STEPS+1];
  cordic_t vec  [CORDIC_STAGES+1];
  div_t    dv   [DIV_STEPS+1];

  // back-end arithmetic
  logic signed [31:0] s_dlat;
  logic signed [31:0] s_dlon;
  logic signed [CW-1:0] c1_full;
  logic signed [CW-1:0] c2_full;
  logic signed [63:0] psq1;
  logic signed [63:0] psq2;
  logic signed [63:0] pcc;
  logic [32:0]        sq1;
  logic signed [CW-1:0] cc;
  logic [32:0]        sq2;
  logic signed [67:0] pt;
  logic signed [39:0] asum;
  logic [30:0]        a_clamped;
  logic [30:0]        a_q30;
  logic [30:0]        h_pos;
  logic [21:0]        rad20;
  logic [52:0]        dprod;
  logic [52:0]        dsum;
  logic [DIST_W-1:0]  dist_c;
  logic [DIST_W-1:0]  distance;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld[PIPE_DEPTH-1];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= RADIUS_RESET;
      travel_speed  <= SPEED_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIUS: sphere_radius <= cfg_data;
        REG_SPEED:  travel_speed  <= cfg_data[SPD_W-1:0];
        default:    ;
      endcase
    end
  end

  // valid line, one bit per pipeline stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // input stage: angle differences and doubled latitudes (half-microdegrees)
  always_ff @(posedge clk) begin
    if (adv) begin
      ang[0] <= ANG_W'(end_latitude) - ANG_W'(start_latitude);
      ang[1] <= ANG_W'(end_longitude) - ANG_W'(start_longitude);
      ang[2] <= {start_latitude[27], start_latitude, 1'b0};
      ang[3] <= {end_latitude[27], end_latitude, 1'b0};
    end
  end

  // rotation CORDIC lanes
  for (genvar l = 0; l < 4; l++) begin : g_lane
    gcft_angle_prep u_prep (
      .clk   (clk),
      .en    (adv),
      .angle (ang[l]),
      .z     (prep_z[l]),
      .flip  (prep_flip[l])
    );

    assign rot[l][0] = '{x: CORDIC_START, y: '0, z: $signed({3'b0, prep_z[l]}),
                         flag: prep_flip[l]};

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
      gcft_cordic_cell u_cell (
        .clk         (clk),
        .en          (adv),
        .vector_mode (1'b0),
        .step        (5'(s)),
        .din         (rot[l][s]),
        .dout        (rot[l][s+1])
      );
    end
  end

  // haversine term: sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2)
  always_comb begin
    s_dlat  = rot[0][CORDIC_STAGES].y[31:0];
    s_dlon  = rot[1][CORDIC_STAGES].y[31:0];
    c1_full = rot[2][CORDIC_STAGES].flag ? -rot[2][CORDIC_STAGES].x
                                         : rot[2][CORDIC_STAGES].x;
    c2_full = rot[3][CORDIC_STAGES].flag ? -rot[3][CORDIC_STAGES].x
                                         : rot[3][CORDIC_STAGES].x;
    cc      = CW'(pcc >>> 30);
    sq2     = 33'(psq2 >>> 30);
    asum    = $signed({7'b0, sq1}) + 40'(pt >>> 30);
    if (asum < 0) begin
      a_clamped = '0;
    end else if (asum > $signed({9'b0, Q30_ONE})) begin
      a_clamped = Q30_ONE;
    end else begin
      a_clamped = asum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      psq1  <= s_dlat * s_dlat;
      psq2  <= s_dlon * s_dlon;
      pcc   <= $signed(c1_full[31:0]) * $signed(c2_full[31:0]);
      sq1   <= 33'(psq1 >>> 30);
      pt    <= 68'(cc) * $signed({1'b0, sq2});
      a_q30 <= a_clamped;
    end
  end

  // sqrt(a) and sqrt(1 - a), Q30 radicands shifted up by 30
  assign sq_y[0] = '{rad: {1'b0, a_q30, 30'b0}, rem: '0, root: '0};
  assign sq_x[0] = '{rad: {1'b0, 31'(Q30_ONE - a_q30), 30'b0}, rem: '0, root: '0};

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    gcft_sqrt_cell u_sqy (
      .clk  (clk),
      .en   (adv),
      .din  (sq_y[s]),
      .dout (sq_y[s+1])
    );
    gcft_sqrt_cell u_sqx (
      .clk  (clk),
      .en   (adv),
      .din  (sq_x[s]),
      .dout (sq_x[s+1])
    );
  end

  // central half-angle h = atan2(sqrt(a), sqrt(1-a))
  assign vec[0] = '{x: $signed({3'b0, sq_x[SQRT_STEPS].root}),
                    y: $signed({3'b0, sq_y[SQRT_STEPS].root}),
                    z: '0, flag: 1'b0};

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
    gcft_cordic_cell u_cell (
      .clk         (clk),
      .en          (adv),
      .vector_mode (1'b1),
      .step        (5'(s)),
      .din         (vec[s]),
      .dout        (vec[s+1])
    );
  end

  // distance = 2 * R * h, radius in tenths of a mile, result in hundredths
  always_comb begin
    h_pos  = vec[CORDIC_STAGES].z[CW-1] ? '0 : vec[CORDIC_STAGES].z[30:0];
    rad20  = 22'(sphere_radius) * 22'd20;
    dsum   = dprod + (53'd1 << 29);
    dist_c = (dsum[52:30] > 23'(DIST_MAX)) ? DIST_MAX : dsum[51:30];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dprod    <= 53'(rad20) * 53'(h_pos);
      distance <= dist_c;
      dv[0]    <= '{num: 29'(distance) * 29'd100 + 29'(travel_speed[SPD_W-1:1]),
                    rem: '0, quo: '0, distance: distance};
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    gcft_div_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .speed (travel_speed),
      .din   (dv[s]),
      .dout  (dv[s+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      arc_distance <= dv[DIV_STEPS].distance;
      travel_time  <= (travel_speed == '0) ? TIME_MAX : dv[DIV_STEPS].quo;
    end
  end

  // input is held back only while a finished item waits at the output
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_frozen_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(vld))
    else $error("pipeline moved while stalled");

  a_bubble_enters: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !in_valid |=> !vld[0])
    else $error("item appeared without input");

endmodule

### rtl/gcft_cordic_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring mode.
module gcft_cordic_cell import gcft_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic       vector_mode,
  input  logic [4:0] step,
  input  cordic_t    din,
  output cordic_t    dout
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] at;
  logic                 up;

  always_comb begin
    xs = din.x >>> step;
    ys = din.y >>> step;
    at = $signed({4'b0, ATAN_Q30[step]});
    // rotate: follow sign of residual angle; vector: drive y to zero
    up = vector_mode ? din.y[CW-1] : !din.z[CW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (up) begin
        dout.x <= din.x - ys;
        dout.y <= din.y + xs;
        dout.z <= din.z - at;
      end else begin
        dout.x <= din.x + ys;
        dout.y <= din.y - xs;
        dout.z <= din.z + at;
      end
      dout.flag <= din.flag;
    end
  end

endmodule

### rtl/gcft_sqrt_cell.sv
// One digit step of a bit-pair integer square root.
module gcft_sqrt_cell import gcft_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t din,
  output sqrt_t dout
);

  logic [34:0] cur;
  logic [34:0] trial;
  logic        ge;

  always_comb begin
    cur   = {din.rem, din.rad[61:60]};
    trial = {2'b00, din.root, 2'b01};
    ge    = cur >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rad  <= {din.rad[59:0], 2'b00};
      dout.rem  <= ge ? 33'(cur - trial) : 33'(cur);
      dout.root <= {din.root[29:0], ge};
    end
  end

endmodule

### rtl/gcft_div_cell.sv
// One quotient bit of a restoring divide by the travel speed.
module gcft_div_cell import gcft_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SPD_W-1:0] speed,
  input  div_t             din,
  output div_t             dout
);

  logic [SPD_W:0] trial;
  logic           ge;

  always_comb begin
    trial = {din.rem, din.num[TIME_W-1]};
    ge    = trial >= {1'b0, speed};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.num      <= {din.num[TIME_W-2:0], 1'b0};
      dout.rem      <= ge ? SPD_W'(trial - {1'b0, speed}) : trial[SPD_W-1:0];
      dout.quo      <= {din.quo[TIME_W-2:0], ge};
      dout.distance <= din.distance;
    end
  end

endmodule

### rtl/gcft_angle_prep.sv
// Angle reduction and half-microdegree to Q30 radian scaling, four stages.
module gcft_angle_prep import gcft_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] angle,
  output logic [Z_W-1:0]          z,
  output logic                    flip
);

  logic signed [ANG_W:0] v;
  logic signed [ANG_W:0] r;
  logic signed [ANG_W:0] f;
  logic                  fold;
  logic [MAG_W-1:0]      mag_c;
  logic [59:0]           scaled;
  logic [102:0]          sum;

  // stage registers
  logic [MAG_W-1:0] mag;
  logic             flip1;
  logic [50:0]      quot_in;
  logic             flip2;
  logic [51:0]      p_hh;
  logic [51:0]      p_hl;
  logic [50:0]      p_lh;
  logic [50:0]      p_ll;
  logic             flip3;

  always_comb begin
    v = {angle[ANG_W-1], angle};
    if (v >= HALF_HU) begin
      r = v - TURN_HU;
    end else if (v < -HALF_HU) begin
      r = v + TURN_HU;
    end else begin
      r = v;
    end
    // fold into [-90, 90] degrees; cosine changes sign
    if (r > QUARTER_HU) begin
      f    = r - HALF_HU;
      fold = 1'b1;
    end else if (r < -QUARTER_HU) begin
      f    = r + HALF_HU;
      fold = 1'b1;
    end else begin
      f    = r;
      fold = 1'b0;
    end
    mag_c  = f[ANG_W] ? MAG_W'(-f) : MAG_W'(f);
    scaled = 60'(mag) * 60'(PI_Q30) + 60'(QUARTER_HU);
    sum    = (103'(p_hh) << 51) + (103'(p_hl) << 25) + (103'(p_lh) << 26) + 103'(p_ll);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag     <= mag_c;
      flip1   <= fold;
      // divide by 360000000 = 512 * 703125
      quot_in <= scaled[59:9];
      flip2   <= flip1;
      p_hh    <= 52'(quot_in[50:25]) * 52'(ANG_RECIP[51:26]);
      p_hl    <= 52'(quot_in[50:25]) * 52'(ANG_RECIP[25:0]);
      p_lh    <= 51'(quot_in[24:0]) * 51'(ANG_RECIP[51:26]);
      p_ll    <= 51'(quot_in[24:0]) * 51'(ANG_RECIP[25:0]);
      flip3   <= flip2;
      z       <= sum[101:71];
      flip    <= flip3;
    end
  end

endmodule
